>>> sv/tkwsc_pkg.sv
// ---------------------------------------------------------------------------
// tkwsc_pkg
// constants, types and the key table of the table-keyed word stream cipher
// ---------------------------------------------------------------------------
package tkwsc_pkg;

   typedef logic [31:0] word_type;
   typedef logic [7:0]  tab_index_type;
   typedef word_type    key_table_type [256];

   localparam word_type SEED_INIT = 32'hEEEE_EEEE;
   localparam word_type LCG_START = 32'h0010_0001;
   localparam word_type LCG_MUL   = 32'd125;
   localparam word_type LCG_MOD   = 32'h002A_AAAB;
   localparam word_type LCG_INC   = 32'd3;
   localparam word_type KEY_ADD   = 32'h1111_1111;
   localparam int       KEY_SHL   = 'h15;
   localparam int       KEY_SHR   = 'h0B;
   localparam int       LAST_COL  = 4;

   localparam int          CSR_ADDR_W    = 3;
   localparam logic        REG_DIRECTION = 1'b0;
   localparam logic        DIR_ENCRYPT   = 1'b0;
   localparam logic        DIR_DECRYPT   = 1'b1;

   function automatic word_type lcg_next(word_type s);
      return (s * LCG_MUL + LCG_INC) % LCG_MOD;
   endfunction

   function automatic key_table_type gen_key_table();
      key_table_type tab;
      word_type      s;
      word_type      hi;
      word_type      lo;
      s = LCG_START;
      for (int row = 0; row < 256; row++) begin
         for (int col = 0; col <= LAST_COL; col++) begin
            s  = lcg_next(s);
            hi = {s[15:0], 16'h0000};
            s  = lcg_next(s);
            lo = {16'h0000, s[15:0]};
            if (col == LAST_COL) begin
               tab[row] = hi | lo;
            end
         end
      end
      return tab;
   endfunction

   localparam key_table_type KEY_TABLE = gen_key_table();

   function automatic word_type key_step(word_type k);
      return ((~k << KEY_SHL) + KEY_ADD) | (k >> KEY_SHR);
   endfunction

endpackage

>>> sv/tkwsc_if.sv
// ---------------------------------------------------------------------------
// tkwsc_req_if / tkwsc_rsp_if
// valid/ready channels of the cipher: word items in, result items out
// ---------------------------------------------------------------------------
interface tkwsc_req_if
   import tkwsc_pkg::*;
   ();
   logic     valid;
   logic     ready;
   word_type data_word;
   word_type block_key;
   logic     start_of_block;

   modport source (output valid, output data_word, output block_key,
                   output start_of_block, input ready);
   modport sink   (input valid, input data_word, input block_key,
                   input start_of_block, output ready);
endinterface

interface tkwsc_rsp_if
   import tkwsc_pkg::*;
   ();
   logic     valid;
   logic     ready;
   word_type result_word;

   modport source (output valid, output result_word, input ready);
   modport sink   (input valid, input result_word, output ready);
endinterface

>>> sv/table_keyed_word_stream_cipher.sv
// ---------------------------------------------------------------------------
// table_keyed_word_stream_cipher
// word-serial block cipher keyed by a constant 256-word table
// ---------------------------------------------------------------------------
// req channel: one 32-bit word per item; start_of_block loads block_key and
// restarts the seed chain. rsp channel: one result word per item.
// csr port: direction register at byte 0 (0 encrypt, 1 decrypt), to be
// written only while the block is idle; the block does not enforce this.
// A req item passes the stage 1 and output registers to rsp valid. One item
// per cycle while rsp is not stalled: the key chain runs in the accept stage
// and addresses the table rom (registered read), the seed chain closes in the
// second stage, whose one add/xor loop sets the rate.
// When rsp is stalled the output register holds its item, the first stage
// takes one more item, then req_ready drops until rsp moves again.
// Synchronous reset empties the pipe, clears the key to zero, sets the seed
// to 0xEEEEEEEE and the direction to encrypt; the table is constant and
// needs no clearing pass.
// ---------------------------------------------------------------------------
module table_keyed_word_stream_cipher
   import tkwsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tkwsc_req_if.sink             req_ch,
   tkwsc_rsp_if.source           rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic     direction_ff;
   word_type key_ff, key_in;
   word_type seed_ff, seed_in;

   logic     s1_valid_ff;
   word_type s1_key_ff;
   word_type s1_word_ff;
   logic     s1_start_ff;
   word_type tab_ff;

   logic     out_valid_ff;
   word_type out_word_ff;

   logic     req_acc;
   logic     s1_adv;
   word_type cur_key;
   word_type cur_seed;
   word_type res_word;
   word_type plain_word;
   logic     csr_wr;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[CSR_ADDR_W-1] == REG_DIRECTION);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_DIRECTION) ?
                       {31'd0, direction_ff} : 32'd0;

   // handshake
   assign s1_adv       = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_acc      = req_ch.valid && req_ch.ready;

   // key chain and table address
   always_comb begin
      cur_key = req_ch.start_of_block ? req_ch.block_key : key_ff;
      key_in  = req_acc ? key_step(cur_key) : key_ff;
   end

   // seed chain
   always_comb begin
      cur_seed   = (s1_start_ff ? SEED_INIT : seed_ff) + tab_ff;
      res_word   = s1_word_ff ^ (s1_key_ff + cur_seed);
      plain_word = (direction_ff == DIR_DECRYPT) ? res_word : s1_word_ff;
      seed_in    = s1_adv ? (plain_word + cur_seed + (cur_seed << 5) + LCG_INC)
                          : seed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_ENCRYPT;
         key_ff       <= '0;
         seed_ff      <= SEED_INIT;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            direction_ff <= csr_pwdata[0];
         end
         key_ff  <= key_in;
         seed_ff <= seed_in;
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // table rom with registered read, loaded with the stage 1 payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_key_ff   <= cur_key;
         s1_word_ff  <= req_ch.data_word;
         s1_start_ff <= req_ch.start_of_block;
         tab_ff      <= KEY_TABLE[cur_key[7:0]];
      end
      if (s1_adv) begin
         out_word_ff <= res_word;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.result_word = out_word_ff;

   // checks
   a_adv_fills_out: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> out_valid_ff)
      else $error("stage 1 item did not reach the output register");

   a_start_loads_key: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_ch.start_of_block |=> s1_key_ff == $past(req_ch.block_key))
      else $error("block key not taken on start item");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> s1_valid_ff && out_valid_ff && !rsp_ch.ready)
      else $error("req stalled while the pipe has room");

   a_key_held_idle: assert property (@(posedge clock) disable iff (reset)
      !req_acc |=> key_ff == $past(key_ff))
      else $error("running key moved without an item");

endmodule
